// File: sv/assert_macros.svh
// Assertion helpers used by the filter top level, iir_filter_direct_form_one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Types, sizes and register indexes of the direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    localparam int FF_TAPS     = 4;
    localparam int FB_TAPS     = 4;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int ROUND_SHIFT = 14;
    localparam int RES_W       = ACC_W - ROUND_SHIFT;
    localparam int CFG_IDX_W   = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RES_W-1:0]    res_t;

    localparam coef_t   FF0_RESET  = 16'sd16384;
    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam acc_t    ROUND_HALF = acc_t'(1) <<< (ROUND_SHIFT - 1);
    localparam res_t    RES_MAX    = res_t'(SAMPLE_MAX);
    localparam res_t    RES_MIN    = res_t'(SAMPLE_MIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_FF_COEF_0 = 4'd0,
        IDX_FF_COEF_1 = 4'd1,
        IDX_FF_COEF_2 = 4'd2,
        IDX_FF_COEF_3 = 4'd3,
        IDX_FB_COEF_1 = 4'd4,
        IDX_FB_COEF_2 = 4'd5,
        IDX_FB_COEF_3 = 4'd6,
        IDX_FB_COEF_4 = 4'd7
    } cfg_idx_e;

    typedef struct packed {
        logic    restart;
        sample_t sample_in;
    } in_item_t;

    typedef struct packed {
        sample_t sample_out;
        logic    clipped;
    } out_item_t;

    typedef struct packed {
        coef_t [FF_TAPS-1:0] ff;
        coef_t [FB_TAPS-1:0] fb;
    } coef_set_t;

    // Delay line contents as seen by the arithmetic for the current sample.
    typedef struct packed {
        sample_t [FF_TAPS-2:0] x;
        sample_t [FB_TAPS-1:0] y;
    } hist_t;

endpackage

// File: sv/iirdf1_coef_bank.sv
// ----------------------------------------------------------------------------
// iirdf1_coef_bank
// Coefficient registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module iirdf1_coef_bank import iirdf1_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  coef_t                wr_data,
    output coef_set_t            coef
);

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            case (cfg_idx_e'(wr_index))
                IDX_FF_COEF_0: coef_next.ff[0] = wr_data;
                IDX_FF_COEF_1: coef_next.ff[1] = wr_data;
                IDX_FF_COEF_2: coef_next.ff[2] = wr_data;
                IDX_FF_COEF_3: coef_next.ff[3] = wr_data;
                IDX_FB_COEF_1: coef_next.fb[0] = wr_data;
                IDX_FB_COEF_2: coef_next.fb[1] = wr_data;
                IDX_FB_COEF_3: coef_next.fb[2] = wr_data;
                IDX_FB_COEF_4: coef_next.fb[3] = wr_data;
                // Indexes past the register list are dropped.
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '{ff: {coef_t'(0), coef_t'(0), coef_t'(0), FF0_RESET}, fb: '0};
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// File: sv/iirdf1_history.sv
// ----------------------------------------------------------------------------
// iirdf1_history
// Input and output delay lines, with clearing on a restart sample.
// ----------------------------------------------------------------------------
module iirdf1_history import iirdf1_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    restart,
    input  sample_t x_new,
    input  sample_t y_new,
    output hist_t   hist
);

    hist_t hist_reg;
    hist_t hist_next;

    // A restart sample sees empty history and starts the lines afresh.
    assign hist = restart ? '0 : hist_reg;

    always_comb begin
        hist_next = hist_reg;
        if (step) begin
            hist_next.x[0] = x_new;
            for (int k = 1; k < FF_TAPS - 1; k++) begin
                hist_next.x[k] = hist.x[k-1];
            end
            hist_next.y[0] = y_new;
            for (int k = 1; k < FB_TAPS; k++) begin
                hist_next.y[k] = hist.y[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else begin
            hist_reg <= hist_next;
        end
    end

endmodule

// File: sv/iirdf1_mac.sv
// ----------------------------------------------------------------------------
// iirdf1_mac
// Eight parallel products, summed, rounded to Q1.15 and saturated.
// ----------------------------------------------------------------------------
module iirdf1_mac import iirdf1_pkg::*; (
    input  sample_t   x,
    input  hist_t     hist,
    input  coef_set_t coef,
    output out_item_t result
);

    logic signed [PROD_W-1:0] prod_ff [FF_TAPS];
    logic signed [PROD_W-1:0] prod_fb [FB_TAPS];
    acc_t acc;
    acc_t acc_rnd;
    res_t rounded;

    always_comb begin
        prod_ff[0] = $signed(coef.ff[0]) * $signed(x);
        for (int k = 1; k < FF_TAPS; k++) begin
            prod_ff[k] = $signed(coef.ff[k]) * $signed(hist.x[k-1]);
        end
        for (int k = 0; k < FB_TAPS; k++) begin
            prod_fb[k] = $signed(coef.fb[k]) * $signed(hist.y[k]);
        end
    end

    always_comb begin
        acc = '0;
        for (int k = 0; k < FF_TAPS; k++) begin
            acc = acc + acc_t'(prod_ff[k]);
        end
        for (int k = 0; k < FB_TAPS; k++) begin
            acc = acc - acc_t'(prod_fb[k]);
        end
    end

    // Round half up: add half an output LSB, then drop the low bits.
    assign acc_rnd = acc + ROUND_HALF;
    assign rounded = acc_rnd[ACC_W-1:ROUND_SHIFT];

    always_comb begin
        if (rounded > RES_MAX) begin
            result.sample_out = SAMPLE_MAX;
            result.clipped    = 1'b1;
        end else if (rounded < RES_MIN) begin
            result.sample_out = SAMPLE_MIN;
            result.clipped    = 1'b1;
        end else begin
            result.sample_out = rounded[SAMPLE_W-1:0];
            result.clipped    = 1'b0;
        end
    end

endmodule

// File: sv/iir_filter_direct_form_one.sv
// ----------------------------------------------------------------------------
// iir_filter_direct_form_one
// Direct-form-I IIR filter, four feedforward and four feedback taps.
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel (restart flag and Q1.15 sample) and one
// filtered sample with a clip flag leaves on the m_ channel for each of them.
// Coefficients (Q2.14) are written on the cfg_ channel, which is always
// ready; indexes 0 to 3 are the feedforward taps, 4 to 7 the feedback taps,
// and any other index is ignored. Write them only while the filter is idle.
// A transaction taken on s_ is held in an input register; from there the
// whole sum of products, rounding and saturation is worked out and loaded
// into the output register once that register is free, which raises m_valid.
// One sample is taken per cycle for as long as the receiver keeps up; the
// feedback through the registered output history sets that limit.
// When m_ready is low the output register holds its transaction, the input
// register can still take one more, and s_ready then falls until m_ready
// returns. Reset empties both registers, zeros both delay lines and sets the
// first feedforward coefficient to 1.0 and all others to zero. A restart
// sample zeros the delay lines before it is filtered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iir_filter_direct_form_one import iirdf1_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coef_t                cfg_data
);

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      step;
    coef_set_t coef;
    hist_t     hist;
    out_item_t result;

    assign cfg_ready = 1'b1;

    iirdf1_coef_bank u_coef_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    iirdf1_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .restart (in_item_reg.restart),
        .x_new   (in_item_reg.sample_in),
        .y_new   (result.sample_out),
        .hist    (hist)
    );

    iirdf1_mac u_mac (
        .x      (in_item_reg.sample_in),
        .hist   (hist),
        .coef   (coef),
        .result (result)
    );

    // The output register frees up when empty or when its transaction leaves.
    assign advance = !out_valid_reg || m_ready;
    assign step    = advance && in_valid_reg;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    `ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg), "input register lost a waiting transaction")
    `ASSERT_IMPLY(a_clip_limit, aclk, aresetn, out_valid_reg && out_item_reg.clipped,
        out_item_reg.sample_out == SAMPLE_MAX || out_item_reg.sample_out == SAMPLE_MIN,
        "clipped result is not at a range limit")
    `ASSERT_NEXT(a_cfg_ff0, aclk, aresetn,
        cfg_valid && cfg_ready && cfg_index == IDX_FF_COEF_0,
        coef.ff[0] == $past(cfg_data), "coefficient write to first tap not taken")

endmodule
